[src/aabbfc_pkg.sv]
// Package for the box frustum culler: field widths, plane counts and shared types.
// No dependencies; every other file takes names from here by scope.
package aabbfc_pkg;

   localparam int COORD_W     = 32;   // box coordinate, signed Q20.12
   localparam int ENTRY_W     = 24;   // matrix entry, signed Q8.16
   localparam int PAIR_W      = 2 * ENTRY_W;
   localparam int COEF_W      = ENTRY_W + 1;       // plane coefficient, signed Q9.16
   localparam int PROD_W      = COEF_W + COORD_W;  // one exact product, Q.28
   localparam int SUM_W       = PROD_W + 2;        // four terms, exact
   localparam int W_SHIFT     = 12;   // align w (Q.16) to products (Q.28)
   localparam int NUM_PLANES  = 6;
   localparam int NUM_AXES    = 3;
   localparam int NUM_TERMS   = NUM_AXES + 1;
   localparam int NUM_ENTRIES = 16;
   localparam int NUM_PAIRS   = 8;
   localparam int PAIR_IDX_W  = 3;
   localparam int CSR_INDEX_W = 4;    // one spare bit so out-of-range writes are seen

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ENTRY_W-1:0] entry_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic [PAIR_W-1:0]         pair_type;
   typedef logic [CSR_INDEX_W-1:0]    csr_index_type;

   typedef struct packed {
      coord_type min_x;
      coord_type min_y;
      coord_type min_z;
      coord_type max_x;
      coord_type max_y;
      coord_type max_z;
   } box_type;

endpackage

[src/aabbfc_channels.sv]
// Valid/ready channel interfaces for the culler: box words in, visible words out,
// and matrix register writes. Depends on aabbfc_pkg.
interface aabbfc_req_if;
   logic                  valid;
   logic                  ready;
   aabbfc_pkg::coord_type box_min_x;
   aabbfc_pkg::coord_type box_min_y;
   aabbfc_pkg::coord_type box_min_z;
   aabbfc_pkg::coord_type box_max_x;
   aabbfc_pkg::coord_type box_max_y;
   aabbfc_pkg::coord_type box_max_z;

   modport source (output valid, box_min_x, box_min_y, box_min_z,
                   box_max_x, box_max_y, box_max_z, input ready);
   modport sink   (input valid, box_min_x, box_min_y, box_min_z,
                   box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface aabbfc_rsp_if;
   logic valid;
   logic ready;
   logic visible;

   modport source (output valid, visible, input ready);
   modport sink   (input valid, visible, output ready);
endinterface

interface aabbfc_csr_if;
   logic                      valid;
   logic                      ready;
   aabbfc_pkg::csr_index_type index;
   aabbfc_pkg::pair_type      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[src/aabbfc_planes.sv]
// Matrix register file and frustum plane derivation for the culler.
// Depends on aabbfc_pkg and aabbfc_csr_if.
module aabbfc_planes (
   input  logic                 clock,
   input  logic                 reset,
   aabbfc_csr_if.sink           csr_chan,
   output aabbfc_pkg::coef_type planes [aabbfc_pkg::NUM_PLANES][aabbfc_pkg::NUM_TERMS]
);

   aabbfc_pkg::pair_type  matrix_ff [aabbfc_pkg::NUM_PAIRS];
   aabbfc_pkg::entry_type m         [aabbfc_pkg::NUM_ENTRIES];
   aabbfc_pkg::coef_type  planes_in [aabbfc_pkg::NUM_PLANES][aabbfc_pkg::NUM_TERMS];
   aabbfc_pkg::coef_type  planes_ff [aabbfc_pkg::NUM_PLANES][aabbfc_pkg::NUM_TERMS];
   logic                  wr_hit;

   assign csr_chan.ready = 1'b1;
   assign wr_hit = csr_chan.valid && csr_chan.ready &&
                   (csr_chan.index < aabbfc_pkg::CSR_INDEX_W'(aabbfc_pkg::NUM_PAIRS));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < aabbfc_pkg::NUM_PAIRS; k++) begin
            matrix_ff[k] <= '0;
         end
      end else if (wr_hit) begin
         matrix_ff[csr_chan.index[aabbfc_pkg::PAIR_IDX_W-1:0]] <= csr_chan.data;
      end
   end

   // Split the pairs into entries, then form row 3 plus and minus rows 0..2.
   always_comb begin
      for (int k = 0; k < aabbfc_pkg::NUM_PAIRS; k++) begin
         m[2*k]   = matrix_ff[k][aabbfc_pkg::ENTRY_W-1:0];
         m[2*k+1] = matrix_ff[k][aabbfc_pkg::PAIR_W-1:aabbfc_pkg::ENTRY_W];
      end
      for (int r = 0; r < aabbfc_pkg::NUM_AXES; r++) begin
         for (int a = 0; a < aabbfc_pkg::NUM_TERMS; a++) begin
            planes_in[2*r][a]   = aabbfc_pkg::COEF_W'(m[3+4*a]) +
                                  aabbfc_pkg::COEF_W'(m[r+4*a]);
            planes_in[2*r+1][a] = aabbfc_pkg::COEF_W'(m[3+4*a]) -
                                  aabbfc_pkg::COEF_W'(m[r+4*a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < aabbfc_pkg::NUM_PLANES; p++) begin
            for (int a = 0; a < aabbfc_pkg::NUM_TERMS; a++) begin
               planes_ff[p][a] <= '0;
            end
         end
      end else begin
         planes_ff <= planes_in;
      end
   end

   assign planes = planes_ff;

endmodule

[src/aabb_frustum_cull.sv]
// Top level of the box frustum culler: four-stage dot-product pipeline.
// Depends on aabbfc_pkg, the channel interfaces and aabbfc_planes.
//
//   channel   dir  word                                   accepted when
//   req_chan  in   box_min_x/y/z, box_max_x/y/z (Q20.12)  valid && ready
//   rsp_chan  out  visible                                valid && ready
//   csr_chan  in   index (0..7 = matrix_pair_k), data     valid && ready (ready tied high)
//
// One box per cycle sustained while rsp_chan.ready keeps up; a box's verdict shows on
// rsp_chan after four register stages (input register, product stage, pair-sum
// stage, result), the first of which loads at the edge that accepts it.
// The plane coefficients are re-registered from the matrix every cycle, so a
// matrix write is in force for a box accepted on a later cycle.
// Reset (synchronous, active high) clears the matrix, planes and all valid bits.
// Each stage holds while its successor is full and stalled; bubbles collapse,
// so words keep entering while a finished verdict waits for rsp_chan.ready.
module aabb_frustum_cull (
   input  logic          clock,
   input  logic          reset,
   aabbfc_req_if.sink    req_chan,
   aabbfc_rsp_if.source  rsp_chan,
   aabbfc_csr_if.sink    csr_chan
);

   aabbfc_pkg::coef_type planes [aabbfc_pkg::NUM_PLANES][aabbfc_pkg::NUM_TERMS];

   // Stage 1: captured box.
   logic                 v1_ff;
   aabbfc_pkg::box_type  box1_ff;
   // Stage 2: three products and the aligned w term per plane.
   logic                 v2_ff;
   aabbfc_pkg::prod_type prod_in  [aabbfc_pkg::NUM_PLANES][aabbfc_pkg::NUM_TERMS];
   aabbfc_pkg::prod_type prod2_ff [aabbfc_pkg::NUM_PLANES][aabbfc_pkg::NUM_TERMS];
   // Stage 3: two partial sums per plane.
   logic                 v3_ff;
   aabbfc_pkg::sum_type  sum_in   [aabbfc_pkg::NUM_PLANES][2];
   aabbfc_pkg::sum_type  sum3_ff  [aabbfc_pkg::NUM_PLANES][2];
   // Stage 4: verdict, which is the output register.
   logic                 v4_ff;
   logic                 visible_ff;
   logic                 visible_in;

   logic                 ready1, ready2, ready3, ready4;
   aabbfc_pkg::coord_type lo [aabbfc_pkg::NUM_AXES];
   aabbfc_pkg::coord_type hi [aabbfc_pkg::NUM_AXES];

   aabbfc_planes u_planes (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .planes   (planes)
   );

   // A stage loads when it is empty or its successor takes its word.
   assign ready4 = !v4_ff || rsp_chan.ready;
   assign ready3 = !v3_ff || ready4;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;
   assign req_chan.ready = ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= req_chan.valid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
         if (ready4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         box1_ff.min_x <= req_chan.box_min_x;
         box1_ff.min_y <= req_chan.box_min_y;
         box1_ff.min_z <= req_chan.box_min_z;
         box1_ff.max_x <= req_chan.box_max_x;
         box1_ff.max_y <= req_chan.box_max_y;
         box1_ff.max_z <= req_chan.box_max_z;
      end
   end

   // Pick the positive corner per plane and axis: max where the coefficient
   // is above zero, min otherwise (a zero coefficient takes min).
   always_comb begin
      lo[0] = box1_ff.min_x;
      lo[1] = box1_ff.min_y;
      lo[2] = box1_ff.min_z;
      hi[0] = box1_ff.max_x;
      hi[1] = box1_ff.max_y;
      hi[2] = box1_ff.max_z;
      for (int p = 0; p < aabbfc_pkg::NUM_PLANES; p++) begin
         for (int a = 0; a < aabbfc_pkg::NUM_AXES; a++) begin
            prod_in[p][a] = aabbfc_pkg::PROD_W'(planes[p][a]) *
               aabbfc_pkg::PROD_W'((!planes[p][a][aabbfc_pkg::COEF_W-1] &&
                                    (planes[p][a] != '0)) ? hi[a] : lo[a]);
         end
         prod_in[p][aabbfc_pkg::NUM_AXES] =
            aabbfc_pkg::PROD_W'(planes[p][aabbfc_pkg::NUM_AXES]) <<< aabbfc_pkg::W_SHIFT;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2) prod2_ff <= prod_in;
   end

   always_comb begin
      for (int p = 0; p < aabbfc_pkg::NUM_PLANES; p++) begin
         sum_in[p][0] = aabbfc_pkg::SUM_W'(prod2_ff[p][0]) +
                        aabbfc_pkg::SUM_W'(prod2_ff[p][1]);
         sum_in[p][1] = aabbfc_pkg::SUM_W'(prod2_ff[p][2]) +
                        aabbfc_pkg::SUM_W'(prod2_ff[p][3]);
      end
   end

   always_ff @(posedge clock) begin
      if (ready3) sum3_ff <= sum_in;
   end

   // Drop the box if any plane distance is negative; zero counts as inside.
   always_comb begin
      aabbfc_pkg::sum_type plane_dist;
      visible_in = 1'b1;
      for (int p = 0; p < aabbfc_pkg::NUM_PLANES; p++) begin
         plane_dist = sum3_ff[p][0] + sum3_ff[p][1];
         if (plane_dist[aabbfc_pkg::SUM_W-1]) visible_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ready4) visible_ff <= visible_in;
   end

   assign rsp_chan.valid   = v4_ff;
   assign rsp_chan.visible = visible_ff;

endmodule

[verif/tb_aabb_frustum_cull.sv]
`timescale 1ns / 100ps
// Testbench for aabb_frustum_cull: directed and random boxes under several matrices,
// each verdict checked in order against a positive-vertex plane predictor.
// Depends on aabbfc_pkg, the channel interfaces in aabbfc_channels.sv and the RTL.

module tb_aabb_frustum_cull;

   localparam int IDLE_LIMIT   = 2000;  // cycles with no word moving on any channel
   localparam int HOLD_CYCLES  = 120;   // one long receiver hold-off
   localparam int DRAIN_CYCLES = 20;    // well past the pipeline latency
   localparam int MAX_GAP      = 10;
   localparam int PHASES       = 8;
   localparam int PHASE_BOXES  = 250;
   localparam int IDLE_REDRAW  = 40;    // words between idle policy changes

   localparam aabbfc_pkg::coord_type ONE   = 32'sd4096;           // 1.0 in Q20.12
   localparam aabbfc_pkg::coord_type HALF  = 32'sd2048;
   localparam aabbfc_pkg::coord_type C_MIN = 32'sh8000_0000;
   localparam aabbfc_pkg::coord_type C_MAX = 32'sh7FFF_FFFF;
   localparam aabbfc_pkg::entry_type UNIT  = 24'sd65536;          // 1.0 in Q8.16
   localparam aabbfc_pkg::entry_type E_MIN = 24'sh80_0000;
   localparam aabbfc_pkg::entry_type E_MAX = 24'sh7F_FFFF;

   typedef enum int {
      MAT_IDENTITY,
      MAT_PERSPECTIVE,
      MAT_NOISE,
      MAT_EXTREME
   } matrix_mode_type;

   typedef struct {
      aabbfc_pkg::box_type box;
      bit                  visible;
   } verdict_type;

   // Holds the matrix as the block should see it and the verdicts still owed.
   class frustum_verdicts;
      aabbfc_pkg::pair_type matrix_pairs[aabbfc_pkg::NUM_PAIRS];
      verdict_type          pending[$];

      function new();
         foreach (matrix_pairs[k]) matrix_pairs[k] = '0;
      endfunction

      function void load_pair(aabbfc_pkg::csr_index_type index, aabbfc_pkg::pair_type data);
         if (index < aabbfc_pkg::NUM_PAIRS)
            matrix_pairs[index[aabbfc_pkg::PAIR_IDX_W-1:0]] = data;
      endfunction

      // Row 3 plus and minus rows 0..2 give the six planes; pick the far corner
      // per axis and reject on any negative exact distance.
      function bit box_in_frustum(aabbfc_pkg::box_type b);
         longint                lo[aabbfc_pkg::NUM_AXES];
         longint                hi[aabbfc_pkg::NUM_AXES];
         longint                m[aabbfc_pkg::NUM_ENTRIES];
         longint                plane[aabbfc_pkg::NUM_PLANES][aabbfc_pkg::NUM_TERMS];
         longint                plane_dist;
         aabbfc_pkg::entry_type e;
         bit                    in_view;
         lo[0] = b.min_x;  lo[1] = b.min_y;  lo[2] = b.min_z;
         hi[0] = b.max_x;  hi[1] = b.max_y;  hi[2] = b.max_z;
         for (int i = 0; i < aabbfc_pkg::NUM_ENTRIES; i++) begin
            e    = matrix_pairs[i / 2][(i % 2) * aabbfc_pkg::ENTRY_W +: aabbfc_pkg::ENTRY_W];
            m[i] = e;
         end
         for (int r = 0; r < aabbfc_pkg::NUM_AXES; r++) begin
            for (int a = 0; a < aabbfc_pkg::NUM_TERMS; a++) begin
               plane[2 * r][a]     = m[3 + 4 * a] + m[r + 4 * a];
               plane[2 * r + 1][a] = m[3 + 4 * a] - m[r + 4 * a];
            end
         end
         in_view = 1'b1;
         for (int p = 0; p < aabbfc_pkg::NUM_PLANES; p++) begin
            plane_dist = plane[p][aabbfc_pkg::NUM_AXES] <<< aabbfc_pkg::W_SHIFT;
            for (int a = 0; a < aabbfc_pkg::NUM_AXES; a++)
               plane_dist += plane[p][a] * (plane[p][a] > 0 ? hi[a] : lo[a]);
            if (plane_dist < 0) in_view = 1'b0;
         end
         return in_view;
      endfunction

      function void note_box(aabbfc_pkg::box_type b);
         verdict_type v;
         v.box     = b;
         v.visible = box_in_frustum(b);
         pending   = {pending, v};
      endfunction

      function bit check_verdict(logic visible, output string why);
         verdict_type v;
         why = "";
         if (pending.size() == 0) begin
            why = $sformatf("visible %b with no box outstanding", visible);
            return 1'b0;
         end
         v = pending.pop_front();
         if (visible !== v.visible) begin
            why = $sformatf("visible %b, expected %b, box min %0d %0d %0d max %0d %0d %0d",
                            visible, v.visible, v.box.min_x, v.box.min_y, v.box.min_z,
                            v.box.max_x, v.box.max_y, v.box.max_z);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function int outstanding();
         return pending.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   aabbfc_req_if req_chan ();
   aabbfc_rsp_if rsp_chan ();
   aabbfc_csr_if csr_chan ();

   frustum_verdicts verdicts;
   int  mismatch_count   = 0;
   int  stall_cycles     = 0;
   bit  hold_off_pending = 1'b0;  // set by the stimulus, cleared by the receiver
   bit  send_idle_on     = 1'b0;
   bit  take_idle_on     = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   aabb_frustum_cull i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   function automatic aabbfc_pkg::box_type corners(
         aabbfc_pkg::coord_type min_x, aabbfc_pkg::coord_type min_y,
         aabbfc_pkg::coord_type min_z, aabbfc_pkg::coord_type max_x,
         aabbfc_pkg::coord_type max_y, aabbfc_pkg::coord_type max_z);
      return {min_x, min_y, min_z, max_x, max_y, max_z};
   endfunction

   // Mostly small boxes around the origin, where the planes of the test matrices
   // actually cut; some raw 32-bit noise and some boundary values.
   function automatic aabbfc_pkg::box_type random_box();
      aabbfc_pkg::coord_type c[2 * aabbfc_pkg::NUM_AXES];
      int        pick;
      int        lo;
      int        hi;
      int        t;
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
         foreach (c[i]) c[i] = $urandom;
      end else if (pick < 5) begin
         foreach (c[i]) begin
            case ($urandom_range(0, 7))
               0:       c[i] = C_MIN;
               1:       c[i] = C_MAX;
               2:       c[i] = 0;
               3:       c[i] = -1;
               4:       c[i] = ONE;
               5:       c[i] = -ONE;
               6:       c[i] = ONE + 1;
               default: c[i] = -ONE - 1;
            endcase
         end
      end else begin
         for (int a = 0; a < aabbfc_pkg::NUM_AXES; a++) begin
            lo = int'($urandom_range(0, 6 * ONE)) - 3 * ONE;
            hi = lo + int'($urandom_range(0, 2 * ONE));
            // now and then hand over a box with min above max
            if ($urandom_range(0, 15) == 0) begin
               t  = lo;
               lo = hi;
               hi = t;
            end
            c[a]                       = lo;
            c[a + aabbfc_pkg::NUM_AXES] = hi;
         end
      end
      return {c[0], c[1], c[2], c[3], c[4], c[5]};
   endfunction

   function automatic void make_matrix(matrix_mode_type mode,
         output aabbfc_pkg::entry_type ents[aabbfc_pkg::NUM_ENTRIES]);
      foreach (ents[i]) ents[i] = '0;
      case (mode)
         MAT_IDENTITY: begin
            ents[0]  = UNIT;
            ents[5]  = UNIT;
            ents[10] = UNIT;
            ents[15] = UNIT;
         end
         MAT_PERSPECTIVE: begin
            // small skew everywhere, scaled diagonal, w taken from -z
            foreach (ents[i])
               ents[i] = aabbfc_pkg::entry_type'(int'($urandom_range(0, 8192)) - 4096);
            ents[0]  = aabbfc_pkg::entry_type'($urandom_range(UNIT / 2, 2 * UNIT));
            ents[5]  = aabbfc_pkg::entry_type'($urandom_range(UNIT / 2, 2 * UNIT));
            ents[10] = -aabbfc_pkg::entry_type'($urandom_range(UNIT / 2, 2 * UNIT));
            ents[14] = -aabbfc_pkg::entry_type'($urandom_range(0, 2 * UNIT));
            ents[11] = -UNIT;
         end
         MAT_NOISE: begin
            foreach (ents[i]) ents[i] = aabbfc_pkg::entry_type'($urandom);
         end
         default: begin
            foreach (ents[i]) begin
               case ($urandom_range(0, 4))
                  0:       ents[i] = E_MIN;
                  1:       ents[i] = E_MAX;
                  2:       ents[i] = UNIT;
                  3:       ents[i] = -UNIT;
                  default: ents[i] = '0;
               endcase
            end
         end
      endcase
   endfunction

   // Write all eight pairs, then two stray indexes past the last one; the
   // block must drop those. Valid stays high across the burst.
   task automatic write_matrix(aabbfc_pkg::entry_type ents[aabbfc_pkg::NUM_ENTRIES]);
      aabbfc_pkg::csr_index_type idx;
      aabbfc_pkg::pair_type      data;
      for (int k = 0; k < aabbfc_pkg::NUM_PAIRS + 2; k++) begin
         if (k < aabbfc_pkg::NUM_PAIRS) begin
            idx  = aabbfc_pkg::csr_index_type'(k);
            data = {ents[2 * k + 1], ents[2 * k]};
         end else begin
            idx  = aabbfc_pkg::csr_index_type'($urandom_range(aabbfc_pkg::NUM_PAIRS,
                                                2 ** aabbfc_pkg::CSR_INDEX_W - 1));
            data = {16'($urandom), 32'($urandom)};
         end
         csr_chan.index <= idx;
         csr_chan.data  <= data;
         csr_chan.valid <= 1'b1;
         do @(posedge clock); while (!csr_chan.ready);
      end
      csr_chan.valid <= 1'b0;
   endtask

   // Offer one box word, after a random gap when idling is on.
   task automatic send_box(aabbfc_pkg::box_type b);
      int gap;
      gap = send_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.box_min_x <= b.min_x;
      req_chan.box_min_y <= b.min_y;
      req_chan.box_min_z <= b.min_z;
      req_chan.box_max_x <= b.max_x;
      req_chan.box_max_y <= b.max_y;
      req_chan.box_max_z <= b.max_z;
      req_chan.valid     <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop valid and hold until every owed verdict has come back.
   task automatic finish_burst();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (verdicts.outstanding() != 0);
   endtask

   // Receiver: random stalls, clean stretches, and one long hold-off on request
   // so the pipeline fills and backs up into the input channel.
   initial begin : verdict_taker
      int gap;
      int taken;
      taken = 0;
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % IDLE_REDRAW == 0) take_idle_on = $urandom_range(0, 1);
         gap = take_idle_on ? $urandom_range(0, MAX_GAP) : 0;
         if (hold_off_pending) begin
            gap              = HOLD_CYCLES;
            hold_off_pending = 1'b0;
         end
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         taken++;
      end
   end

   // Sample every channel at the edge: note accepted boxes, apply register
   // writes to the predictor, check verdicts, and count idle cycles.
   always @(posedge clock) begin : word_monitor
      string               why;
      aabbfc_pkg::box_type b;
      bit                  moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            b = corners(req_chan.box_min_x, req_chan.box_min_y, req_chan.box_min_z,
                        req_chan.box_max_x, req_chan.box_max_y, req_chan.box_max_z);
            verdicts.note_box(b);
            moved = 1'b1;
         end
         if (csr_chan.valid && csr_chan.ready) begin
            verdicts.load_pair(csr_chan.index, csr_chan.data);
            moved = 1'b1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (!verdicts.check_verdict(rsp_chan.visible, why)) report_mismatch(why);
            moved = 1'b1;
         end
      end
      stall_cycles <= moved ? 0 : stall_cycles + 1;
   end

   initial begin : watchdog
      do @(posedge clock); while (stall_cycles < IDLE_LIMIT);
      $display("%0t no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      aabbfc_pkg::entry_type ents[aabbfc_pkg::NUM_ENTRIES];
      verdicts = new();
      req_chan.valid     <= 1'b0;
      req_chan.box_min_x <= '0;
      req_chan.box_min_y <= '0;
      req_chan.box_min_z <= '0;
      req_chan.box_max_x <= '0;
      req_chan.box_max_y <= '0;
      req_chan.box_max_z <= '0;
      csr_chan.valid     <= 1'b0;
      csr_chan.index     <= '0;
      csr_chan.data      <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Matrix still zero from reset: every plane is zero, so all boxes pass.
      send_idle_on = $urandom_range(0, 1);
      send_box(corners(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
      send_box(corners(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));
      send_box(corners(ONE, -ONE, ONE, ONE, -ONE, ONE));
      finish_burst();

      // Identity: the frustum is the cube [-1, 1] with w = 1, many coefficients zero.
      make_matrix(MAT_IDENTITY, ents);
      write_matrix(ents);
      send_box(corners(-HALF, -HALF, -HALF, HALF, HALF, HALF));
      send_box(corners(-2 * ONE, -HALF, -HALF, -ONE, HALF, HALF));      // left distance zero
      send_box(corners(-2 * ONE, -HALF, -HALF, -ONE - 1, HALF, HALF));  // just outside
      send_box(corners(ONE, -HALF, -HALF, 2 * ONE, HALF, HALF));        // right distance zero
      send_box(corners(ONE + 1, -HALF, -HALF, 2 * ONE, HALF, HALF));
      send_box(corners(-HALF, -HALF, ONE, HALF, HALF, 2 * ONE));        // far distance zero
      send_box(corners(HALF, HALF, HALF, -HALF, -HALF, -HALF));         // min above max
      send_box(corners(2 * ONE, 2 * ONE, 2 * ONE, -2 * ONE, -2 * ONE, -2 * ONE));
      send_box(corners(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
      send_box(corners(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
      send_box(corners(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
      finish_burst();

      // Every entry at its most negative, then at its most positive: widest sums.
      foreach (ents[i]) ents[i] = E_MIN;
      write_matrix(ents);
      send_box(corners(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
      send_box(corners(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
      finish_burst();
      foreach (ents[i]) ents[i] = E_MAX;
      write_matrix(ents);
      send_box(corners(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
      send_box(corners(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
      finish_burst();

      // Random phases, each under a fresh matrix; one phase gets the long hold-off.
      for (int ph = 0; ph < PHASES; ph++) begin
         make_matrix(matrix_mode_type'(ph % 4), ents);
         write_matrix(ents);
         if (ph == 2) hold_off_pending = 1'b1;
         for (int n = 0; n < PHASE_BOXES; n++) begin
            if (n % IDLE_REDRAW == 0) send_idle_on = $urandom_range(0, 1);
            send_box(random_box());
         end
         finish_burst();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (verdicts.outstanding() != 0)
         report_mismatch($sformatf("%0d verdicts never arrived", verdicts.outstanding()));
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[aabb_frustum_cull.f]
src/aabbfc_pkg.sv
src/aabbfc_channels.sv
src/aabbfc_planes.sv
src/aabb_frustum_cull.sv
verif/tb_aabb_frustum_cull.sv
